### src/nfcrfp_pkg.sv
// Shared types and constants for the NFC response frame parser.
`timescale 1ns / 1ps

package nfcrfp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } nfcrfp_in_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [1:0] verdict;
    logic [7:0] response_code;
  } nfcrfp_out_t;

  localparam int unsigned ADDR_W = 4;

  // register word indexes (paddr[3:2])
  localparam logic [1:0] REG_EXP_CMD    = 2'd0;
  localparam logic [1:0] REG_RSP_OFFSET = 2'd1;
  localparam logic [1:0] REG_DIR_CODE   = 2'd2;
  localparam logic [1:0] REG_MAX_LEN    = 2'd3;

  localparam logic [7:0] RST_EXP_CMD    = 8'h00;
  localparam logic [7:0] RST_RSP_OFFSET = 8'h01;
  localparam logic [7:0] RST_DIR_CODE   = 8'hD5;
  localparam logic [7:0] RST_MAX_LEN    = 8'hFF;

  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_LAST = 8'hFF;
  localparam logic [7:0] MIN_LEN    = 8'd2;

  localparam logic       KIND_DATA    = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;

  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_FRAME    = 2'd1;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd2;

endpackage

### src/nfc_response_frame_parser.sv
// Top level: byte-serial response frame parser with APB register port.
// A result is registered: it appears on out_item in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while no held result stalls the input; the single output
// register lets a new byte enter while the current result is taken in the same cycle.
// Reset (rst, synchronous): parser goes back to start-code hunt, output empty,
// registers return to their default values.
`timescale 1ns / 1ps

module nfc_response_frame_parser
  import nfcrfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nfcrfp_in_t        in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output nfcrfp_out_t       out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_LCS, PH_TFI, PH_CMD, PH_DATA, PH_DCS, PH_DONE
  } phase_t;

  logic [7:0] expected_command;
  logic [7:0] response_offset;
  logic [7:0] direction_code;
  logic [7:0] max_packet_len;

  phase_t     phase, phase_next;
  logic [1:0] start_match, start_match_next;
  logic [7:0] packet_length, packet_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic       direction_bad, direction_bad_next;
  logic       code_bad, code_bad_next;
  logic [7:0] seen_code, seen_code_next;

  logic        res_valid;
  nfcrfp_out_t res;
  logic        in_fire;
  logic        cfg_wr;
  logic [7:0]  b;
  logic        last;
  logic [7:0]  dcs_sum;
  logic [7:0]  len_chk;
  logic [7:0]  exp_code;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;
  assign b        = in_item.rx_byte;
  assign last     = in_item.end_of_buffer;
  assign dcs_sum  = running_sum + b;
  assign len_chk  = packet_length + b;
  assign exp_code = expected_command + response_offset;

  always_comb begin
    unique case (paddr[3:2])
      REG_EXP_CMD:    prdata = {24'd0, expected_command};
      REG_RSP_OFFSET: prdata = {24'd0, response_offset};
      REG_DIR_CODE:   prdata = {24'd0, direction_code};
      REG_MAX_LEN:    prdata = {24'd0, max_packet_len};
      default:        prdata = 32'd0;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    start_match_next   = start_match;
    packet_length_next = packet_length;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    direction_bad_next = direction_bad;
    code_bad_next      = code_bad;
    seen_code_next     = seen_code;
    res_valid          = 1'b0;
    res.item_kind      = KIND_VERDICT;
    res.payload_byte   = 8'd0;
    res.verdict        = VERDICT_FRAME;
    res.response_code  = seen_code;

    if (phase == PH_DONE) begin
      if (last) begin
        phase_next = PH_HUNT;
        start_match_next = 2'd0; packet_length_next = 8'd0; bytes_left_next = 8'd0;
        running_sum_next = 8'd0; direction_bad_next = 1'b0; code_bad_next = 1'b0;
        seen_code_next = 8'd0;
      end
    end else if (phase == PH_DCS || last) begin
      // verdict beat: DCS byte, or an early end of buffer
      res_valid = 1'b1;
      if (phase == PH_DCS) begin
        if (direction_bad)        res.verdict = VERDICT_FRAME;
        else if (code_bad)        res.verdict = VERDICT_MISMATCH;
        else if (dcs_sum != 8'd0) res.verdict = VERDICT_FRAME;
        else                      res.verdict = VERDICT_OK;
      end
      if (last) begin
        phase_next = PH_HUNT;
        start_match_next = 2'd0; packet_length_next = 8'd0; bytes_left_next = 8'd0;
        running_sum_next = 8'd0; direction_bad_next = 1'b0; code_bad_next = 1'b0;
        seen_code_next = 8'd0;
      end else begin
        running_sum_next = dcs_sum;
        phase_next = PH_DONE;
      end
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (start_match >= 2'd2) begin
            if (b == START_LAST) begin
              phase_next = PH_LEN;
              start_match_next = 2'd0; packet_length_next = 8'd0;
              bytes_left_next = 8'd0; running_sum_next = 8'd0;
              direction_bad_next = 1'b0; code_bad_next = 1'b0;
              seen_code_next = 8'd0;
            end else if (b != START_ZERO) begin
              start_match_next = 2'd0;
            end
          end else begin
            start_match_next = (b == START_ZERO) ? start_match + 2'd1 : 2'd0;
          end
        end
        PH_LEN: begin
          packet_length_next = b;
          phase_next = PH_LCS;
        end
        PH_LCS: begin
          if (packet_length < MIN_LEN || packet_length > max_packet_len ||
              len_chk != 8'd0) begin
            res_valid  = 1'b1;
            phase_next = PH_DONE;
          end else begin
            bytes_left_next = packet_length - MIN_LEN;
            phase_next = PH_TFI;
          end
        end
        PH_TFI: begin
          running_sum_next   = b;
          direction_bad_next = (b != direction_code);
          phase_next = PH_CMD;
        end
        PH_CMD: begin
          running_sum_next = dcs_sum;
          seen_code_next   = b;
          code_bad_next    = (b != exp_code);
          phase_next = (bytes_left == 8'd0) ? PH_DCS : PH_DATA;
        end
        PH_DATA: begin
          running_sum_next = dcs_sum;
          bytes_left_next  = bytes_left - 8'd1;
          if (bytes_left == 8'd1) phase_next = PH_DCS;
          res_valid        = 1'b1;
          res.item_kind    = KIND_DATA;
          res.payload_byte = b;
          res.verdict      = VERDICT_OK;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= RST_EXP_CMD;
      response_offset  <= RST_RSP_OFFSET;
      direction_code   <= RST_DIR_CODE;
      max_packet_len   <= RST_MAX_LEN;
      phase            <= PH_HUNT;
      start_match      <= 2'd0;
      packet_length    <= 8'd0;
      bytes_left       <= 8'd0;
      running_sum      <= 8'd0;
      direction_bad    <= 1'b0;
      code_bad         <= 1'b0;
      seen_code        <= 8'd0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_EXP_CMD:    expected_command <= pwdata[7:0];
          REG_RSP_OFFSET: response_offset  <= pwdata[7:0];
          REG_DIR_CODE:   direction_code   <= pwdata[7:0];
          REG_MAX_LEN:    max_packet_len   <= pwdata[7:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase         <= phase_next;
        start_match   <= start_match_next;
        packet_length <= packet_length_next;
        bytes_left    <= bytes_left_next;
        running_sum   <= running_sum_next;
        direction_bad <= direction_bad_next;
        code_bad      <= code_bad_next;
        seen_code     <= seen_code_next;
        out_valid     <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, no reset needed on the payload
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_item <= res;
    end
  end

endmodule

### dv/nfcrfp_checker.sv
// Checker for the NFC response frame parser: byte-level prediction and beat compare.
`timescale 1ns / 1ps

module nfcrfp_checker
  import nfcrfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  nfcrfp_in_t        in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  nfcrfp_out_t       out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                payload_seen,
  output int                verdict_seen
);

  typedef enum logic [2:0] {
    ST_HUNT, ST_LEN, ST_LCS, ST_TFI, ST_CMD, ST_DATA, ST_DCS, ST_DONE
  } parse_state_t;

  // shadow copy of the register file
  logic [7:0] cmd_q, off_q, dir_q, maxlen_q;

  parse_state_t state;
  logic [1:0]   zero_run;
  logic [7:0]   frame_len;
  logic [7:0]   data_left;
  logic [7:0]   csum;
  logic         dir_err;
  logic         code_err;
  logic [7:0]   rsp_code;

  nfcrfp_out_t  frame_beats[$];
  nfcrfp_out_t  oldest;

  initial begin
    fail_count   = 0;
    pending      = 0;
    payload_seen = 0;
    verdict_seen = 0;
  end

  function automatic void restart_frame();
    state     = ST_HUNT;
    zero_run  = 2'd0;
    frame_len = 8'h00;
    data_left = 8'h00;
    csum      = 8'h00;
    dir_err   = 1'b0;
    code_err  = 1'b0;
    rsp_code  = 8'h00;
  endfunction

  // verdict carries the code seen so far; frame state clears only on end of buffer
  function automatic void close_frame(input logic [1:0] v, input logic last);
    nfcrfp_out_t r;
    r.item_kind     = KIND_VERDICT;
    r.payload_byte  = 8'h00;
    r.verdict       = v;
    r.response_code = rsp_code;
    frame_beats = {frame_beats, r};
    if (last) restart_frame();
    else state = ST_DONE;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    nfcrfp_out_t r;
    if (state == ST_DONE) begin
      if (last) restart_frame();
      return;
    end
    if (state == ST_DCS) begin
      csum = csum + b;
      if (dir_err) close_frame(VERDICT_FRAME, last);
      else if (code_err) close_frame(VERDICT_MISMATCH, last);
      else if (csum != 8'h00) close_frame(VERDICT_FRAME, last);
      else close_frame(VERDICT_OK, last);
      return;
    end
    // end flag anywhere before DCS: truncated frame
    if (last) begin
      close_frame(VERDICT_FRAME, 1'b1);
      return;
    end
    case (state)
      ST_HUNT: begin
        if (zero_run >= 2'd2) begin
          if (b == START_LAST) begin
            restart_frame();
            state = ST_LEN;
          end else if (b != START_ZERO) begin
            zero_run = 2'd0;
          end
        end else begin
          zero_run = (b == START_ZERO) ? zero_run + 2'd1 : 2'd0;
        end
      end
      ST_LEN: begin
        frame_len = b;
        state     = ST_LCS;
      end
      ST_LCS: begin
        if (frame_len < MIN_LEN || frame_len > maxlen_q || 8'(frame_len + b) != 8'h00) begin
          close_frame(VERDICT_FRAME, 1'b0);
        end else begin
          data_left = frame_len - MIN_LEN;
          state     = ST_TFI;
        end
      end
      ST_TFI: begin
        csum    = b;
        dir_err = (b != dir_q);
        state   = ST_CMD;
      end
      ST_CMD: begin
        csum     = csum + b;
        rsp_code = b;
        code_err = (b != 8'(cmd_q + off_q));
        state    = (data_left == 8'h00) ? ST_DCS : ST_DATA;
      end
      default: begin
        csum      = csum + b;
        data_left = data_left - 8'd1;
        if (data_left == 8'h00) state = ST_DCS;
        r.item_kind     = KIND_DATA;
        r.payload_byte  = b;
        r.verdict       = VERDICT_OK;
        r.response_code = rsp_code;
        frame_beats = {frame_beats, r};
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cmd_q    = RST_EXP_CMD;
      off_q    = RST_RSP_OFFSET;
      dir_q    = RST_DIR_CODE;
      maxlen_q = RST_MAX_LEN;
      restart_frame();
      frame_beats.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_EXP_CMD:    cmd_q    = pwdata[7:0];
          REG_RSP_OFFSET: off_q    = pwdata[7:0];
          REG_DIR_CODE:   dir_q    = pwdata[7:0];
          REG_MAX_LEN:    maxlen_q = pwdata[7:0];
          default: ;
        endcase
      end
      // a result can never stem from the byte taken at the same edge
      if (out_valid && out_ready) begin
        if (frame_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d byte %0h verdict %0d",
                 out_item.item_kind, out_item.payload_byte, out_item.verdict);
          fail_count++;
        end else begin
          oldest = frame_beats.pop_front();
          check_field("item_kind", 8'(oldest.item_kind), 8'(out_item.item_kind));
          check_field("payload_byte", oldest.payload_byte, out_item.payload_byte);
          check_field("verdict", 8'(oldest.verdict), 8'(out_item.verdict));
          check_field("response_code", oldest.response_code, out_item.response_code);
          if (oldest.item_kind == KIND_DATA) payload_seen++;
          else verdict_seen++;
        end
      end
      if (in_valid && in_ready) predict_byte(in_item.rx_byte, in_item.end_of_buffer);
      pending = frame_beats.size();
    end
  end

endmodule

### dv/tb_nfc_response_frame_parser.sv
// Testbench top for the NFC response frame parser: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module tb_nfc_response_frame_parser;
  import nfcrfp_pkg::*;

  localparam int ITEM_TARGET    = 450;
  localparam int PHASE_BYTES    = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_LIGHT} pace_t;

  typedef enum int {
    FLAW_NONE, FLAW_LCS, FLAW_LEN_HIGH, FLAW_LEN_LOW, FLAW_DIR,
    FLAW_CODE, FLAW_DCS, FLAW_TRUNC, FLAW_NOISE
  } frame_flaw_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  nfcrfp_in_t        in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  nfcrfp_out_t       out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count, pending, payload_seen, verdict_seen;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int settings_used = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  pace_t tx_pace = PACE_RANDOM;
  pace_t rx_pace = PACE_RANDOM;
  bit    hold_req = 1'b0;

  // register values currently in force, used to build well-formed frames
  logic [7:0] cur_cmd = RST_EXP_CMD;
  logic [7:0] cur_off = RST_RSP_OFFSET;
  logic [7:0] cur_dir = RST_DIR_CODE;
  logic [7:0] cur_max = RST_MAX_LEN;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nfc_response_frame_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  nfcrfp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .payload_seen(payload_seen),
    .verdict_seen(verdict_seen)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("tb_nfc_response_frame_parser: FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(input pace_t pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 16);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver: random stalls per beat, plus one long hold-off on request
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        gap = draw_gap(rx_pace);
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready = 1'b1;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_gap(tx_pace);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.rx_byte       = b;
    in_item.end_of_buffer = last;
    in_valid              = 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_buffer(input byte_q_t fb);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
    buffers_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, val};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_setting(input int ph);
    logic [7:0] c, o, d, m;
    c = 8'($urandom_range(0, 255));
    o = 8'($urandom_range(0, 255));
    d = 8'($urandom_range(0, 255));
    case (ph)
      0: begin  // response code wraps past 255, zero direction byte
        c = 8'hFF; o = 8'hFF; d = 8'h00; m = 8'hFF;
      end
      1: begin  // length limit below MIN_LEN: every frame fails at LCS
        c = 8'h00; o = 8'h00; d = 8'hFF; m = 8'h01;
      end
      2: m = 8'($urandom_range(2, 16));
      3: begin
        o = RST_RSP_OFFSET; d = RST_DIR_CODE; m = RST_MAX_LEN;
      end
      4: m = 8'hFF;
      default: m = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom_range(2, 255));
    endcase
    write_reg(REG_EXP_CMD, c);
    write_reg(REG_RSP_OFFSET, o);
    write_reg(REG_DIR_CODE, d);
    write_reg(REG_MAX_LEN, m);
    cur_cmd = c;
    cur_off = o;
    cur_dir = d;
    cur_max = m;
    settings_used++;
  endtask

  function automatic frame_flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return FLAW_NONE;
    return frame_flaw_t'(r - 11);
  endfunction

  function automatic int pick_len();
    int plen;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
    if (cur_max >= MIN_LEN && plen > cur_max - MIN_LEN) plen = int'(cur_max - MIN_LEN);
    return plen;
  endfunction

  function automatic void build_frame(input frame_flaw_t flaw, input int plen,
                                      output byte_q_t fb);
    logic [7:0] len, tfi, code, sum, b;
    int dcs_idx;
    fb = {};
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 12)) fb = {fb, rand_byte()};
      return;
    end
    repeat ($urandom_range(0, 2)) fb = {fb, 8'($urandom_range(1, 255))};
    if ($urandom_range(0, 3) == 0) fb = {fb, START_ZERO};
    fb = {fb, START_ZERO};
    fb = {fb, START_ZERO};
    fb = {fb, START_LAST};
    len = 8'(plen + 2);
    if (flaw == FLAW_LEN_LOW) len = 8'($urandom_range(0, 1));
    if (flaw == FLAW_LEN_HIGH) len = (cur_max == 8'hFF) ? 8'h00 : cur_max + 8'd1;
    fb = {fb, len};
    if (flaw == FLAW_LCS) fb = {fb, 8'(8'h00 - len + $urandom_range(1, 255))};
    else fb = {fb, 8'(8'h00 - len)};
    tfi  = cur_dir;
    code = cur_cmd + cur_off;
    if (flaw == FLAW_DIR) tfi = tfi ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CODE) code = code ^ 8'($urandom_range(1, 255));
    fb = {fb, tfi};
    fb = {fb, code};
    sum = tfi + code;
    repeat (plen) begin
      b = rand_byte();
      sum = sum + b;
      fb = {fb, b};
    end
    if (flaw == FLAW_DCS) fb = {fb, 8'(8'h00 - sum + $urandom_range(1, 255))};
    else fb = {fb, 8'(8'h00 - sum)};
    dcs_idx = fb.size() - 1;
    repeat ($urandom_range(0, 2))
      fb = {fb, (($urandom_range(0, 1) == 1) ? 8'h00 : rand_byte())};
    // truncated buffer: end flag lands somewhere before DCS
    if (flaw == FLAW_TRUNC)
      while (fb.size() > $urandom_range(1, dcs_idx)) void'(fb.pop_back());
  endfunction

  initial begin
    byte_q_t fb;
    int phase_end;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // end flag while hunting
    fb = {8'h00};
    send_buffer(fb);
    // LEN of 1 rejected, trailing byte ignored until end flag
    fb = {8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h7E};
    send_buffer(fb);
    // bad direction, code and checksum at once: direction wins
    fb = {8'h00, 8'h00, 8'hFF, 8'h02, 8'hFE, 8'hD4, 8'h02, 8'h55};
    send_buffer(fb);
    // bad code and checksum, FF payload, postamble: mismatch wins
    fb = {8'h00, 8'h00, 8'hFF, 8'h03, 8'hFD, 8'hD5, 8'h02, 8'hFF, 8'h00, 8'h00};
    send_buffer(fb);
    wait_idle();

    for (int ph = 0; bytes_sent < ITEM_TARGET; ph++) begin
      apply_setting(ph);
      tx_pace = pace_t'($urandom_range(0, 2));
      rx_pace = pace_t'($urandom_range(0, 2));
      if (ph == 3) begin
        // long receiver stall while a big payload keeps coming
        hold_req = 1'b1;
        build_frame(FLAW_NONE, 60, fb);
        send_buffer(fb);
      end
      if (ph == 4) begin
        build_frame(FLAW_NONE, 253, fb);
        send_buffer(fb);
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_frame(pick_flaw(), pick_len(), fb);
        send_buffer(fb);
      end
      wait_idle();
    end

    $display("run covered %0d bytes in %0d buffers under %0d register settings",
             bytes_sent, buffers_sent, settings_used + 1);
    $display("checked %0d payload beats and %0d verdicts, %0d long output stall(s)",
             payload_seen, verdict_seen, holds_done);
    if (fail_count == 0)
      $display("tb_nfc_response_frame_parser: PASS");
    else
      $display("tb_nfc_response_frame_parser: FAIL");
    $finish;
  end

endmodule

### files.f
src/nfcrfp_pkg.sv
src/nfc_response_frame_parser.sv
dv/nfcrfp_checker.sv
dv/tb_nfc_response_frame_parser.sv
